// ===== rtl/core/b64e_pkg.sv =====
// Shared types, constants and the symbol-to-ASCII function of the base64 encoder.
// No dependencies; every other file of the block refers to it by scoped names.
package b64e_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SYM_W    = 6;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned NSYM     = 4;
  localparam int unsigned IDX_W    = $clog2(NSYM);
  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0] PAD_CHAR   = 7'h3D;  // '='
  localparam logic [CHAR_W-1:0] CHAR_UC_A  = 7'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_LC_A  = 7'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;  // '+'
  localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'h2F;  // '/'

  // Number of leftover input bits held between bytes
  typedef enum logic [1:0] {
    CNT_0 = 2'd0,
    CNT_2 = 2'd1,
    CNT_4 = 2'd2
  } cnt_e;

  // One input byte's command: up to four symbols, which of them are padding,
  // index of the last one and whether it closes the message
  typedef struct packed {
    logic [NSYM-1:0][SYM_W-1:0] sym;
    logic [NSYM-1:0]            pad;
    logic [IDX_W-1:0]           last;
    logic                       fin;
  } cmd_t;

  // Map a 6-bit symbol onto the standard base64 alphabet
  function automatic logic [CHAR_W-1:0] sym_to_char(input logic [SYM_W-1:0] s);
    logic [CHAR_W-1:0] s7;
    logic [CHAR_W-1:0] ch;
    s7 = CHAR_W'(s);
    if (s < 6'd26) begin
      ch = CHAR_UC_A + s7;
    end else if (s < 6'd52) begin
      ch = CHAR_LC_A + (s7 - 7'd26);
    end else if (s < 6'd62) begin
      ch = CHAR_ZERO + (s7 - 7'd52);
    end else if (s == 6'd62) begin
      ch = CHAR_PLUS;
    end else begin
      ch = CHAR_SLASH;
    end
    return ch;
  endfunction

endpackage

// ===== rtl/core/b64e_byte_if.sv =====
// Valid/ready channel carrying raw input bytes with a last-byte marker.
// Depends on b64e_pkg for the byte width.
interface b64e_byte_if;
  logic                           valid;
  logic                           ready;
  logic [b64e_pkg::BYTE_W-1:0]    data_byte;
  logic                           final_byte;

  modport source  (output valid, data_byte, final_byte, input ready);
  modport sink    (input valid, data_byte, final_byte, output ready);
  modport monitor (input valid, ready, data_byte, final_byte);
endinterface

// ===== rtl/core/b64e_char_if.sv =====
// Valid/ready channel carrying encoded ASCII characters with a last-char marker.
// Depends on b64e_pkg for the character width.
interface b64e_char_if;
  logic                           valid;
  logic                           ready;
  logic [b64e_pkg::CHAR_W-1:0]    out_char;
  logic                           final_char;

  modport source  (output valid, out_char, final_char, input ready);
  modport sink    (input valid, out_char, final_char, output ready);
  modport monitor (input valid, ready, out_char, final_char);
endinterface

// ===== rtl/core/b64e_front.sv =====
// Front end: accepts input bytes, splits them into 6-bit symbols and padding
// and pushes one command per byte. Depends on b64e_pkg and b64e_byte_if.
module b64e_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  b64e_byte_if.sink            byte_i,
  input  logic                 full_i,
  output logic                 push_o,
  output b64e_pkg::cmd_t       cmd_o
);

  b64e_pkg::cnt_e cnt_q, cnt_d;
  logic [3:0]     lb_q, lb_d;
  logic           accept;
  logic [7:0]     b;

  assign byte_i.ready = !full_i;
  assign accept       = byte_i.valid && !full_i;
  assign push_o       = accept;
  assign b            = byte_i.data_byte;

  // Split the byte against the leftover bits
  always_comb begin
    cmd_o      = '0;
    cmd_o.fin  = byte_i.final_byte;
    cnt_d      = cnt_q;
    lb_d       = lb_q;
    unique case (cnt_q)
      b64e_pkg::CNT_2: begin
        cmd_o.sym[0] = {lb_q[1:0], b[7:4]};
        if (byte_i.final_byte) begin
          cmd_o.sym[1] = {b[3:0], 2'b00};
          cmd_o.pad[2] = 1'b1;
          cmd_o.last   = 2'd2;
          cnt_d        = b64e_pkg::CNT_0;
          lb_d         = '0;
        end else begin
          cmd_o.last   = 2'd0;
          cnt_d        = b64e_pkg::CNT_4;
          lb_d         = b[3:0];
        end
      end
      b64e_pkg::CNT_4: begin
        cmd_o.sym[0] = {lb_q, b[7:6]};
        cmd_o.sym[1] = b[5:0];
        cmd_o.last   = 2'd1;
        cnt_d        = b64e_pkg::CNT_0;
        lb_d         = '0;
      end
      default: begin
        cmd_o.sym[0] = b[7:2];
        if (byte_i.final_byte) begin
          cmd_o.sym[1] = {b[1:0], 4'b0000};
          cmd_o.pad[2] = 1'b1;
          cmd_o.pad[3] = 1'b1;
          cmd_o.last   = 2'd3;
          cnt_d        = b64e_pkg::CNT_0;
          lb_d         = '0;
        end else begin
          cmd_o.last   = 2'd0;
          cnt_d        = b64e_pkg::CNT_2;
          lb_d         = {2'b00, b[1:0]};
        end
      end
    endcase
  end

  // Advance the leftover state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= b64e_pkg::CNT_0;
      lb_q  <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
      lb_q  <= lb_d;
    end
  end

endmodule

// ===== rtl/core/b64e_queue.sv =====
// Short command queue between the front end and the character emitter.
// Depends on b64e_pkg for the command type and depth.
module b64e_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  b64e_pkg::cmd_t       cmd_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output b64e_pkg::cmd_t       head_o
);

  localparam int unsigned PW = b64e_pkg::QPTR_W;
  localparam int unsigned CW = b64e_pkg::QCNT_W;

  b64e_pkg::cmd_t  mem_q [b64e_pkg::QDEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(b64e_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  // Wrap the pointers and track the fill level
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(b64e_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(b64e_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/core/b64e_back.sv =====
// Back end: walks the head command one symbol per cycle while the output is not stalled
// and drives the registered character output. Depends on b64e_pkg and b64e_char_if.
module b64e_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  b64e_pkg::cmd_t       head_i,
  output logic                 pop_o,
  b64e_char_if.source          char_o
);

  logic [b64e_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic                        vld_q;
  logic [b64e_pkg::CHAR_W-1:0] char_q, char_d;
  logic                        fin_q, fin_d;
  logic                        load, at_last;

  assign load    = !empty_i && (!vld_q || char_o.ready);
  assign at_last = (idx_q == head_i.last);
  assign pop_o   = load && at_last;

  // Select the next character and step the symbol index
  always_comb begin
    char_d = head_i.pad[idx_q] ? b64e_pkg::PAD_CHAR
                               : b64e_pkg::sym_to_char(head_i.sym[idx_q]);
    fin_d  = head_i.fin && at_last;
    idx_d  = idx_q;
    if (load) begin
      idx_d = at_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        vld_q <= 1'b1;
      end else if (char_o.ready) begin
        vld_q <= 1'b0;
      end
    end
  end

  // Hold the output payload until it is taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_d;
      fin_q  <= fin_d;
    end
  end

  assign char_o.valid      = vld_q;
  assign char_o.out_char   = char_q;
  assign char_o.final_char = fin_q;

endmodule

// ===== rtl/core/base64_stream_encoder_core.sv =====
// Base64 stream encoder: one character per cycle on the output while the sink is ready; a
// byte enters the two-entry command queue when it is accepted, and its first character
// passes through the queue entry and then the output register. Each byte yields one to
// four characters, so the character output register limits the sustained rate. Reset
// clears the leftover bits, queue and output valid.
// Depends on b64e_pkg, b64e_byte_if, b64e_char_if, b64e_front, b64e_queue, b64e_back.
module base64_stream_encoder_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  b64e_byte_if.sink     byte_i,
  b64e_char_if.source   char_o
);

  logic            push, full, pop, empty;
  b64e_pkg::cmd_t  cmd, head;

  // Classify bytes into symbol commands
  b64e_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd)
  );

  // Decouple the two sides
  b64e_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  // Emit characters
  b64e_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .char_o  (char_o)
  );

endmodule

// ===== rtl/core/b64e_checker.sv =====
// Port-level checks on the encoder input and output streams, bound to the top level.
// Depends on b64e_pkg; binds to base64_stream_encoder_core.
module b64e_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [b64e_pkg::BYTE_W-1:0] in_data_i,
  input  logic                        in_final_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [b64e_pkg::CHAR_W-1:0] out_char_i,
  input  logic                        out_final_i
);

  logic [1:0] len_q;
  logic       pad_q;
  logic       acc;
  logic [b64e_pkg::CHAR_W-1:0] c;

  assign acc = out_valid_i && out_ready_i;
  assign c   = out_char_i;

  // Track message length modulo four and whether padding has begun
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      pad_q <= 1'b0;
    end else if (acc) begin
      if (out_final_i) begin
        len_q <= '0;
        pad_q <= 1'b0;
      end else begin
        len_q <= len_q + 1'b1;
        if (c == b64e_pkg::PAD_CHAR) begin
          pad_q <= 1'b1;
        end
      end
    end
  end

  // A waiting input byte holds its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |=>
      in_valid_i && $stable(in_data_i) && $stable(in_final_i))
    else $error("input changed while waiting");

  // A stalled character holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_char_i) && $stable(out_final_i))
    else $error("output changed while stalled");

  // Encoded messages are a multiple of four characters
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && out_final_i |-> len_q == 2'd3)
    else $error("message length not a multiple of four");

  // Once padding starts, only padding follows within the message
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && pad_q |-> c == b64e_pkg::PAD_CHAR)
    else $error("data character after padding");

  // Only alphabet characters or padding are shown
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (c >= 7'h41 && c <= 7'h5A) || (c >= 7'h61 && c <= 7'h7A) ||
      (c >= 7'h30 && c <= 7'h39) || c == 7'h2B || c == 7'h2F ||
      c == b64e_pkg::PAD_CHAR)
    else $error("character outside the base64 alphabet");

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (byte_i.valid),
  .in_ready_i  (byte_i.ready),
  .in_data_i   (byte_i.data_byte),
  .in_final_i  (byte_i.final_byte),
  .out_valid_i (char_o.valid),
  .out_ready_i (char_o.ready),
  .out_char_i  (char_o.out_char),
  .out_final_i (char_o.final_char)
);
